### src/assert_macros.svh
// Assertion macros used by the list engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("list engine: same-cycle check failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("list engine: next-cycle check failed");

`endif

### src/oale_pkg.sv
// Types and constants of the ordered list engine.
`default_nettype none

package oale_pkg;

  localparam int POS_W      = 5;
  localparam int VALUE_W    = 32;
  localparam int RDATA_W    = 32;
  localparam int FIDX_W     = 4;
  localparam int COUNT_W    = 5;
  localparam int IN_TDATA_W = 40;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_REMOVE = 3'd1,
    OP_INSERT = 3'd2,
    OP_ERASE  = 3'd3,
    OP_FIND   = 3'd4,
    OP_READ   = 3'd5,
    OP_WRITE  = 3'd6,
    OP_CLEAR  = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_RANGE    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MOVE,
    S_FIND,
    S_RDWAIT,
    S_DONE
  } state_t;

  // Result of one request; read_data sits in the lowest bits.
  typedef struct packed {
    status_t              status;
    logic [COUNT_W-1:0]   element_count;
    logic [FIDX_W-1:0]    found_index;
    logic [RDATA_W-1:0]   read_data;
  } oale_res_t;

  localparam int RES_W = $bits(oale_res_t);

endpackage

`default_nettype wire

### src/oale_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module oale_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/oale_ctrl.sv
// Request sequencer: count register, shift and search walks over the element RAM.
`default_nettype none

`include "assert_macros.svh"

module oale_ctrl
  import oale_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int DATA_WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // request side
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire op_t                   in_mode,
  input  wire logic [POS_W-1:0]      in_position,
  input  wire logic [VALUE_W-1:0]    in_value,
  // result side
  output logic                       res_valid,
  input  wire logic                  res_ready,
  output oale_res_t                  res,
  // element RAM
  output logic                       mem_we,
  output logic [AW-1:0]              mem_waddr,
  output logic [DATA_WIDTH-1:0]      mem_wdata,
  output logic [AW-1:0]              mem_raddr,
  input  wire logic [DATA_WIDTH-1:0] mem_rdata
);

  state_t state_r, state_nxt;

  logic [CW-1:0] count_r, count_nxt;
  logic          pend_r, pend_nxt;

  op_t                   op_r;
  logic [POS_W-1:0]      pos_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [CW-1:0]         left_r, left_nxt;
  logic [AW-1:0]         src_r, src_nxt;
  logic [AW-1:0]         dst_r, dst_nxt;
  logic [RDATA_W-1:0]    rd_r, rd_nxt;
  logic [FIDX_W-1:0]     fidx_r, fidx_nxt;
  status_t               status_r, status_nxt;

  logic [31:0] pos32, cnt32;
  logic        full, ins_ok, elem_ok, walk_done, hit, is_ins;

  assign pos32     = 32'(pos_r);
  assign cnt32     = 32'(count_r);
  assign full      = (count_r == CW'(DEPTH));
  assign ins_ok    = (pos32 <= cnt32) && !full;
  assign elem_ok   = (pos32 < cnt32);
  assign walk_done = (left_r == '0) && !pend_r;
  assign hit       = pend_r && (mem_rdata == val_r);
  assign is_ins    = (op_r == OP_INSERT);

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = '{status: status_r, element_count: COUNT_W'(count_r),
                       found_index: fidx_r, read_data: rd_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        unique case (op_r)
          OP_INSERT: state_nxt = ins_ok ? S_MOVE : S_DONE;
          OP_ERASE:  state_nxt = elem_ok ? S_MOVE : S_DONE;
          OP_FIND:   state_nxt = S_FIND;
          OP_READ:   state_nxt = elem_ok ? S_RDWAIT : S_DONE;
          default:   state_nxt = S_DONE;
        endcase
      end
      S_MOVE: begin
        if (walk_done) state_nxt = S_DONE;
      end
      S_FIND: begin
        if (hit || walk_done) state_nxt = S_DONE;
      end
      S_RDWAIT: state_nxt = S_DONE;
      S_DONE: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // RAM controls and datapath
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = AW'(pos_r);
    mem_wdata  = val_r;
    mem_raddr  = src_r;
    count_nxt  = count_r;
    pend_nxt   = pend_r;
    left_nxt   = left_r;
    src_nxt    = src_r;
    dst_nxt    = dst_r;
    rd_nxt     = rd_r;
    fidx_nxt   = fidx_r;
    status_nxt = status_r;
    unique case (state_r)
      S_EXEC: begin
        rd_nxt     = '0;
        fidx_nxt   = '0;
        status_nxt = ST_OK;
        pend_nxt   = 1'b0;
        unique case (op_r)
          OP_APPEND: begin
            if (full) begin
              status_nxt = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = AW'(count_r);
              count_nxt = count_r + 1'b1;
            end
          end
          OP_REMOVE: begin
            if (count_r == '0) status_nxt = ST_EMPTY;
            else count_nxt = count_r - 1'b1;
          end
          OP_INSERT: begin
            if (pos32 > cnt32) begin
              status_nxt = ST_RANGE;
            end else if (full) begin
              status_nxt = ST_FULL;
            end else begin
              count_nxt = count_r + 1'b1;
              left_nxt  = CW'(cnt32 - pos32);
              src_nxt   = AW'(cnt32 - 32'd1);
            end
          end
          OP_ERASE: begin
            if (!elem_ok) begin
              status_nxt = ST_RANGE;
            end else begin
              count_nxt = count_r - 1'b1;
              left_nxt  = CW'(cnt32 - pos32 - 32'd1);
              src_nxt   = AW'(pos32 + 32'd1);
            end
          end
          OP_FIND: begin
            status_nxt = ST_NOTFOUND;
            left_nxt   = count_r;
            src_nxt    = '0;
          end
          OP_READ: begin
            if (!elem_ok) status_nxt = ST_RANGE;
            else mem_raddr = AW'(pos_r);
          end
          OP_WRITE: begin
            if (!elem_ok) status_nxt = ST_RANGE;
            else mem_we = 1'b1;
          end
          OP_CLEAR: count_nxt = '0;
        endcase
      end
      S_MOVE: begin
        // write back the word read last cycle, one slot up or down
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = dst_r;
          mem_wdata = mem_rdata;
        end
        if (left_r != '0) begin
          src_nxt  = is_ins ? src_r - 1'b1 : src_r + 1'b1;
          dst_nxt  = is_ins ? src_r + 1'b1 : src_r - 1'b1;
          left_nxt = left_r - 1'b1;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        // gap is open: drop the new word in
        if (walk_done && is_ins) begin
          mem_we = 1'b1;
        end
      end
      S_FIND: begin
        if (left_r != '0) begin
          src_nxt  = src_r + 1'b1;
          dst_nxt  = src_r;
          left_nxt = left_r - 1'b1;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (hit) begin
          status_nxt = ST_OK;
          fidx_nxt   = FIDX_W'(dst_r);
        end
      end
      S_RDWAIT: rd_nxt = RDATA_W'(mem_rdata);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r  <= in_mode;
      pos_r <= in_position;
      val_r <= DATA_WIDTH'(in_value);
    end
    left_r   <= left_nxt;
    src_r    <= src_nxt;
    dst_r    <= dst_nxt;
    rd_r     <= rd_nxt;
    fidx_r   <= fidx_nxt;
    status_r <= status_nxt;
  end

  `ASSERT_NEXT(a_accept_exec, clk, rst_n, in_valid && in_ready, state_r == S_EXEC)
  `ASSERT_NEXT(a_done_idle, clk, rst_n, res_valid && res_ready, state_r == S_IDLE)
  `ASSERT_IMPLY(a_no_stray_wr, clk, rst_n, state_r == S_IDLE || state_r == S_DONE, !mem_we)
  `ASSERT_NEXT(a_count_held, clk, rst_n, state_r == S_IDLE, count_r == $past(count_r))
  `ASSERT_IMPLY(a_count_cap, clk, rst_n, 1'b1, cnt32 <= 32'(DEPTH))

endmodule

`default_nettype wire

### src/ordered_array_list_engine.sv
// Top level of the ordered list engine: stream ports, element RAM, result register.
//
// Fixed-capacity ordered list of up to DEPTH words held in one synchronous RAM,
// with the element count in a register. Each request names an operation in
// in_tuser (append, remove last, insert, erase, find, read, write, clear) and
// returns one result: read data, found index, count after the request and a
// status (ok, full, position out of range, not found, empty). One request is
// worked at a time; a result waits in the output register while the next
// request is taken. Insert and erase walk the words from the position up to
// the count; find walks from index 0 until a match or the count; read waits
// for the registered RAM data. The walks for insert, erase and find are set
// by the single RAM read port: one element is read per cycle and, for insert
// and erase, written back one place up or down in the following cycle,
// overlapped with the next read. Words past the count after an erase, remove
// or clear stay in the RAM and are simply outside the list; the RAM needs no
// clearing after reset.
`default_nettype none

module ordered_array_list_engine
  import oale_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // request stream
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,  // [4:0] position, [36:5] value, rest zero
  input  wire logic [2:0]             in_tuser,  // [2:0] mode
  // result stream
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata  // [31:0] read_data, [35:32] found_index,
                                                 // [40:36] element_count, [43:41] status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                  res_valid, res_ready;
  oale_res_t             res;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

  // output register: frees the sequencer as soon as a result is parked
  logic      out_valid_r;
  oale_res_t out_res_r;

  assign res_ready  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - RES_W)'(0), out_res_r};

  oale_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_mode     (op_t'(in_tuser)),
    .in_position (in_tdata[POS_W-1:0]),
    .in_value    (in_tdata[POS_W +: VALUE_W]),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  // element store
  oale_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

endmodule

`default_nettype wire

### tb/ordered_array_list_engine_tb.sv
// Self-checking testbench for the ordered list engine: shadow list, request and result streams.
`timescale 1ns / 100ps

module ordered_array_list_engine_tb
  import oale_pkg::*;
();

  localparam int LIST_DEPTH = 16;

  // Shadow copy of the list. Each accepted request is applied to it at once,
  // and the result it must produce is queued for the result side to match.
  class list_tracker;
    logic [VALUE_W-1:0] words [LIST_DEPTH];
    int unsigned        count;
    oale_res_t          awaited [$];
    int unsigned        mismatches;

    function new();
      count      = 0;
      mismatches = 0;
      foreach (words[i]) words[i] = '0;
    endfunction

    // Apply one accepted request and queue the result it must give.
    function void note_request(op_t op, logic [POS_W-1:0] pos, logic [VALUE_W-1:0] word);
      oale_res_t   want;
      int unsigned i;
      want        = '0;
      want.status = ST_OK;
      case (op)
        OP_APPEND: begin
          if (count >= LIST_DEPTH) want.status = ST_FULL;
          else begin
            words[count] = word;
            count++;
          end
        end
        OP_REMOVE: begin
          if (count == 0) want.status = ST_EMPTY;
          else count--;
        end
        OP_INSERT: begin
          // position is judged before fullness
          if (pos > count) want.status = ST_RANGE;
          else if (count >= LIST_DEPTH) want.status = ST_FULL;
          else begin
            for (i = count; i > pos; i--) words[i] = words[i-1];
            words[pos] = word;
            count++;
          end
        end
        OP_ERASE: begin
          if (pos >= count) want.status = ST_RANGE;
          else begin
            for (i = pos; i + 1 < count; i++) words[i] = words[i+1];
            count--;
          end
        end
        OP_FIND: begin
          want.status = ST_NOTFOUND;
          for (i = 0; i < count && want.status == ST_NOTFOUND; i++) begin
            if (words[i] == word) begin
              want.found_index = i[FIDX_W-1:0];
              want.status      = ST_OK;
            end
          end
        end
        OP_READ: begin
          if (pos >= count) want.status = ST_RANGE;
          else want.read_data = words[pos];
        end
        OP_WRITE: begin
          if (pos >= count) want.status = ST_RANGE;
          else words[pos] = word;
        end
        default: count = 0;  // clear keeps the stored words
      endcase
      want.element_count = count[COUNT_W-1:0];
      awaited = {awaited, want};
    endfunction

    function void report(string field, logic [RDATA_W-1:0] want, logic [RDATA_W-1:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    // Compare one accepted result with the oldest queued one.
    function void check_result(logic [OUT_TDATA_W-1:0] data);
      oale_res_t got;
      oale_res_t want;
      got = oale_res_t'(data[RES_W-1:0]);
      if (awaited.size() == 0) begin
        mismatches++;
        $display("%0t: result with no request outstanding, expected none, actual %0h",
                 $time, data);
        return;
      end
      want = awaited.pop_front();
      report("read_data", want.read_data, got.read_data);
      report("found_index", RDATA_W'(want.found_index), RDATA_W'(got.found_index));
      report("element_count", RDATA_W'(want.element_count), RDATA_W'(got.element_count));
      report("status", RDATA_W'(want.status), RDATA_W'(got.status));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [4:0] position, [36:5] value, rest zero
  logic [2:0]             in_tuser = '0;   // [2:0] mode
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [31:0] read_data, [35:32] found_index,
                                           // [40:36] element_count, [43:41] status

  list_tracker tracker;
  int unsigned burst_left = 0;

  ordered_array_list_engine #(
    .DEPTH(LIST_DEPTH),
    .DATA_WIDTH(VALUE_W)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run (~1300 requests, each with its
  // walk, result stall and sender gap).
  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Sender pacing: bursts of random length, each followed by a gap that drops
  // tvalid. Zero-length gaps give stretches with no idling at all.
  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Present one request and hold it until the engine takes it. tready is
  // sampled just after the edge, i.e. the value it had at the edge.
  task automatic send_request(op_t op, logic [POS_W-1:0] pos, logic [VALUE_W-1:0] word);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_TDATA_W-POS_W-VALUE_W){1'b0}}, word, pos};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_request(op, pos, word);
    pace();
  endtask

  // Result side: check on each handshake, then pick tready from a pattern
  // whose character is redrawn at random (open, mostly ready, mostly stalled,
  // periodic).
  initial begin : result_side
    int unsigned cyc;
    int unsigned style;
    cyc   = 0;
    style = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) tracker.check_result(out_tdata);
      if (cyc % 48 == 0) style = $urandom_range(0, 3);
      cyc++;
      case (style)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 3) != 0);
        2:       out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= ((cyc % 7) >= 3);
      endcase
    end
  end

  initial begin : request_side
    int unsigned        n;
    int unsigned        target;
    int unsigned        roll;
    op_t                op;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] word;

    tracker = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-list corner cases first
    send_request(OP_REMOVE, 5'd0, 32'h0);            // remove last on empty
    send_request(OP_FIND, 5'd0, 32'h0);              // search on empty
    send_request(OP_ERASE, 5'd0, 32'h1234_5678);     // erase on empty
    send_request(OP_READ, 5'd0, 32'h0);              // read on empty
    send_request(OP_INSERT, 5'd1, 32'h5555_5555);    // insert past the count
    send_request(OP_INSERT, 5'd0, 32'hFFFF_FFFF);
    send_request(OP_APPEND, 5'd16, 32'h0);
    send_request(OP_INSERT, 5'd1, 32'h8000_0001);    // insert in the middle
    // fill to capacity
    for (n = 0; n < LIST_DEPTH - 3; n++) send_request(OP_APPEND, 5'd0, $urandom);
    send_request(OP_APPEND, 5'd0, 32'hAAAA_AAAA);    // append on full list
    send_request(OP_INSERT, 5'd16, 32'hAAAA_AAAA);   // insert on full list, good position
    send_request(OP_READ, 5'd15, 32'h0);
    send_request(OP_WRITE, 5'd16, 32'h0);            // write past the count
    send_request(OP_WRITE, 5'd2, 32'h0000_0001);
    send_request(OP_FIND, 5'd0, 32'h8000_0001);
    send_request(OP_ERASE, 5'd0, 32'h0);             // longest shift down
    send_request(OP_ERASE, 5'd14, 32'h0);            // last element
    send_request(OP_CLEAR, 5'd0, 32'h0);
    send_request(OP_READ, 5'd0, 32'h0);              // read after clear

    // Random: the list is steered towards a moving target length so that it
    // spends time empty, full and everywhere between.
    target = LIST_DEPTH;
    for (n = 0; n < 1250; n++) begin
      if (n % 50 == 0)
        target = ($urandom_range(0, 3) == 0) ? LIST_DEPTH : $urandom_range(0, LIST_DEPTH);
      roll = $urandom_range(0, 99);
      if (roll < 2)
        op = OP_CLEAR;
      else if (roll < 45) begin
        if (tracker.count < target) op = $urandom_range(0, 1) ? OP_APPEND : OP_INSERT;
        else op = $urandom_range(0, 1) ? OP_REMOVE : OP_ERASE;
      end else
        op = op_t'($urandom_range(0, 6));

      // positions mostly near the live range, sometimes anywhere legal
      if ($urandom_range(0, 99) < 85) pos = POS_W'($urandom_range(0, tracker.count));
      else pos = POS_W'($urandom_range(0, LIST_DEPTH));

      // words: full random, a copy of a stored one (search hits), or a small
      // value so duplicates turn up
      roll = $urandom_range(0, 9);
      if (roll < 4 || (roll < 7 && tracker.count == 0))
        word = $urandom;
      else if (roll < 7)
        word = tracker.words[$urandom_range(0, tracker.count - 1)];
      else
        word = $urandom_range(0, 3);

      send_request(op, pos, word);
    end

    in_tvalid <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk);
    // allow time for a stray result to show
    repeat (40) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### ordered_array_list_engine.f
+incdir+src
src/oale_pkg.sv
src/oale_ram.sv
src/oale_ctrl.sv
src/ordered_array_list_engine.sv
tb/ordered_array_list_engine_tb.sv
